>>> design/ilpu_pkg.sv
// ----------------------------------------------------------------------------
// ilpu_pkg: integer literal parser package
// Parse phase encoding, character classes and unit suffix decoding shared by
// the integer literal parser.
// ----------------------------------------------------------------------------
package ilpu_pkg;

  localparam int unsigned CHAR_W  = 8;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned SHIFT_W = 6;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;

  // register word index (paddr[2]) of the mode register
  localparam logic REG_WIDE_MODE = 1'b0;

  // shift amounts of the unit letters
  localparam logic [SHIFT_W-1:0] SHIFT_NONE = 6'd0;
  localparam logic [SHIFT_W-1:0] SHIFT_KILO = 6'd10;
  localparam logic [SHIFT_W-1:0] SHIFT_MEGA = 6'd20;
  localparam logic [SHIFT_W-1:0] SHIFT_GIGA = 6'd30;
  localparam logic [SHIFT_W-1:0] SHIFT_TERA = 6'd40;
  localparam logic [SHIFT_W-1:0] SHIFT_PETA = 6'd50;
  localparam logic [SHIFT_W-1:0] SHIFT_EXA  = 6'd60;

  typedef enum logic [2:0] {
    PH_START = 3'd0,
    PH_ZERO  = 3'd1,
    PH_OCT   = 3'd2,
    PH_HEX   = 3'd3,
    PH_DEC   = 3'd4,
    PH_STOP  = 3'd5
  } phase_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } digit_t;

  // hex digit decode, either case
  function automatic digit_t hex_digit(input logic [CHAR_W-1:0] c);
    digit_t d;
    d.valid = 1'b1;
    d.value = 4'd0;
    if (c inside {["0":"9"]}) begin
      d.value = 4'(c - 8'h30);
    end else if (c inside {["a":"f"]}) begin
      d.value = 4'(c - 8'h57);
    end else if (c inside {["A":"F"]}) begin
      d.value = 4'(c - 8'h37);
    end else begin
      d.valid = 1'b0;
    end
    return d;
  endfunction

  // unit suffix to left shift; t/p/e only in wide mode
  function automatic logic [SHIFT_W-1:0] unit_shift(input logic [CHAR_W-1:0] c,
                                                     input logic wide);
    logic [SHIFT_W-1:0] sh;
    sh = SHIFT_NONE;
    if (c inside {"k", "K"}) begin
      sh = SHIFT_KILO;
    end else if (c inside {"m", "M"}) begin
      sh = SHIFT_MEGA;
    end else if (c inside {"g", "G"}) begin
      sh = SHIFT_GIGA;
    end else if (wide && (c inside {"t", "T"})) begin
      sh = SHIFT_TERA;
    end else if (wide && (c inside {"p", "P"})) begin
      sh = SHIFT_PETA;
    end else if (wide && (c inside {"e", "E"})) begin
      sh = SHIFT_EXA;
    end
    return sh;
  endfunction

endpackage

>>> design/integer_literal_parser_with_units.sv
// Result path: the digit update of the last character is registered in the
// finish stage, then sign/unit are applied into the output register.
// Throughput: one character per cycle while s_tready is high; the digit
// update (acc*10 + d as shift-and-add) is the loop that sets that rate.
// Reset: synchronous, clears the parse state and both result stages and
// sets wide_mode to 1.
// ----------------------------------------------------------------------------
// integer_literal_parser_with_units
// Streams one literal a character per transfer, accumulates it in the base
// chosen by its prefix, then applies sign, unit suffix and result width.
// ----------------------------------------------------------------------------
module integer_literal_parser_with_units
  import ilpu_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // input stream
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [CHAR_W-1:0]   s_tdata,   // [7:0] character
  input  logic                s_tlast,   // last character of the literal
  // output stream
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [VALUE_W-1:0]  m_tdata,   // [63:0] value (signed)
  // configuration
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  // configuration register
  logic wide_mode;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      wide_mode <= 1'b1;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_WIDE_MODE)) begin
      wide_mode <= pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_WIDE_MODE) begin
      prdata[0] = wide_mode;
    end
  end

  // parse state
  phase_t               phase, phase_next;
  logic                 negative, negative_next;
  logic [VALUE_W-1:0]   acc, acc_next;

  // finish stage: accumulated literal waiting for sign and unit
  logic                 fin_valid;
  logic [VALUE_W-1:0]   fin_acc;
  logic                 fin_neg;
  logic [SHIFT_W-1:0]   fin_shift;
  logic                 fin_wide;

  logic                 out_ready;
  logic                 fin_ready;
  logic                 accept;
  digit_t               hd;
  logic [3:0]           dval;

  assign out_ready = !m_tvalid || m_tready;
  assign fin_ready = !fin_valid || out_ready;
  assign s_tready  = fin_ready;
  assign accept    = s_tvalid && s_tready;

  // digit update for the current character
  always_comb begin
    hd            = hex_digit(s_tdata);
    dval          = 4'(s_tdata - 8'h30);
    phase_next    = phase;
    negative_next = negative;
    acc_next      = acc;
    case (phase)
      PH_START: begin
        if (s_tdata == "+") begin
          phase_next = PH_START;
        end else if (s_tdata == "-") begin
          negative_next = !negative;
        end else if (s_tdata == "0") begin
          phase_next = PH_ZERO;
        end else if (s_tdata inside {["1":"9"]}) begin
          acc_next   = VALUE_W'(dval);
          phase_next = PH_DEC;
        end else begin
          phase_next = PH_STOP;
        end
      end
      PH_ZERO: begin
        if (s_tdata inside {"x", "X"}) begin
          phase_next = PH_HEX;
        end else if (s_tdata inside {["0":"7"]}) begin
          acc_next   = VALUE_W'(dval);
          phase_next = PH_OCT;
        end else begin
          phase_next = PH_STOP;
        end
      end
      PH_OCT: begin
        if (s_tdata inside {["0":"7"]}) begin
          acc_next = {acc[VALUE_W-4:0], 3'b000} + VALUE_W'(dval);
        end else begin
          phase_next = PH_STOP;
        end
      end
      PH_HEX: begin
        if (hd.valid) begin
          acc_next = {acc[VALUE_W-5:0], 4'b0000} + VALUE_W'(hd.value);
        end else begin
          phase_next = PH_STOP;
        end
      end
      PH_DEC: begin
        if (s_tdata inside {["0":"9"]}) begin
          // acc * 10 = acc * 8 + acc * 2
          acc_next = {acc[VALUE_W-4:0], 3'b000} + {acc[VALUE_W-2:0], 1'b0}
                     + VALUE_W'(dval);
        end else begin
          phase_next = PH_STOP;
        end
      end
      default: begin
        phase_next = PH_STOP;
      end
    endcase
  end

  // parse state registers; cleared after the last character
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_START;
      negative <= 1'b0;
      acc      <= '0;
    end else if (accept) begin
      if (s_tlast) begin
        phase    <= PH_START;
        negative <= 1'b0;
        acc      <= '0;
      end else begin
        phase    <= phase_next;
        negative <= negative_next;
        acc      <= acc_next;
      end
    end
  end

  // finish stage
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (fin_ready) begin
      fin_valid <= accept && s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && s_tlast) begin
      fin_acc   <= acc_next;
      fin_neg   <= negative_next;
      fin_shift <= unit_shift(s_tdata, wide_mode);
      fin_wide  <= wide_mode;
    end
  end

  // sign, unit shift and width
  logic [VALUE_W-1:0] signed_val;
  logic [VALUE_W-1:0] shifted_val;
  logic [VALUE_W-1:0] result;

  always_comb begin
    signed_val  = fin_neg ? (VALUE_W'(0) - fin_acc) : fin_acc;
    shifted_val = signed_val << fin_shift;
    if (fin_wide) begin
      result = shifted_val;
    end else begin
      result = {{(VALUE_W/2){shifted_val[VALUE_W/2-1]}}, shifted_val[VALUE_W/2-1:0]};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && fin_valid) begin
      m_tdata <= result;
    end
  end

  // checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (fin_valid && m_tvalid))
    else $error("input stalled while a result stage is free");

  a_state_cleared_after_last: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tlast) |=> (phase == PH_START && !negative && acc == '0))
    else $error("parse state not cleared after last character");

  a_finish_moves_out: assert property (@(posedge clk) disable iff (rst)
    (fin_valid && out_ready) |=> m_tvalid)
    else $error("finished literal did not reach the output register");

  a_stop_holds_acc: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_STOP && !(accept && s_tlast)) |=> $stable(acc))
    else $error("accumulator changed after parsing stopped");

endmodule
